// ===== hw/rtl/tiled_texture_decoder_core_macros.svh =====
// Assertion macros of the tiled texture decoder, used by its top-level core.
`ifndef TILED_TEXTURE_DECODER_CORE_MACROS_SVH
`define TILED_TEXTURE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TTD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ttd_pkg.sv =====
// Shared types, constants and helpers of the tiled texture decoder.
package ttd_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = 11;   // holds 0..2047 as written by software
  localparam int COORD_W = 10;
  localparam int POS_W   = 12;   // internal coordinate, may run past the image
  localparam int TILE_W  = 8;
  localparam int BYTE_W  = 6;
  localparam int AR_PAIRS = 16;
  localparam int REG_IDX_W = 2;

  typedef enum logic [1:0] {
    FMT_I8    = 2'd0,
    FMT_I4    = 2'd1,
    FMT_RGBA8 = 2'd2
  } fmt_t;

  localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    fmt_t             fmt;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               last_pixel;
  } pixel_t;

  // Up to two pixels from one source byte; v1 only ever set together with v0.
  typedef struct packed {
    logic   v0;
    logic   v1;
    pixel_t p0;
    pixel_t p1;
  } pix_pair_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ttd_if.sv =====
// Channel interfaces: texture byte input, pixel output, register write.
interface ttd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       first_byte;

  modport source (output valid, source_byte, first_byte, input ready);
  modport sink (input valid, source_byte, first_byte, output ready);
endinterface

interface ttd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ttd_pkg::COORD_W-1:0] pixel_x;
  logic [ttd_pkg::COORD_W-1:0] pixel_y;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  logic [7:0]                  alpha;
  logic                        last_pixel;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, alpha, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, red, green, blue, alpha, last_pixel,
                output ready);
endinterface

interface ttd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ttd_pkg::REG_IDX_W-1:0] reg_index;
  logic [ttd_pkg::DIM_W-1:0]     write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

// ===== hw/rtl/ttd_decode.sv =====
// Tile walker, AR pair store and per-byte pixel decode.
module ttd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         source_byte,
  input  logic               first_byte,
  input  ttd_pkg::cfg_t      cfg,
  output ttd_pkg::pix_pair_t pair
);

  logic [ttd_pkg::TILE_W-1:0] col_r, row_r, col_e, row_e;
  logic [ttd_pkg::BYTE_W-1:0] bit_r, bit_e, b;
  logic [7:0]                 green_r;
  logic [7:0]                 alpha_mem [ttd_pkg::AR_PAIRS];
  logic [7:0]                 red_mem   [ttd_pkg::AR_PAIRS];

  logic [ttd_pkg::DIM_W-1:0]  w, h;
  logic                       is_rgba, fmt_ok, tile_end;
  logic [1:0]                 tw_log, th_log;
  logic [ttd_pkg::POS_W-1:0]  w_ext, h_ext, across, down;
  logic [ttd_pkg::POS_W-1:0]  bx, by, x0, y0, x1;
  logic [ttd_pkg::POS_W-1:0]  col_inc, row_inc;
  logic [3:0]                 p;
  logic [7:0]                 hi, lo, ar_a_r, ar_r_r;

  assign col_e = first_byte ? '0 : col_r;
  assign row_e = first_byte ? '0 : row_r;
  assign bit_e = first_byte ? '0 : bit_r;

  assign w       = ttd_pkg::clamp_dim(cfg.width);
  assign h       = ttd_pkg::clamp_dim(cfg.height);
  assign w_ext   = ttd_pkg::POS_W'(w);
  assign h_ext   = ttd_pkg::POS_W'(h);
  assign is_rgba = (cfg.fmt == ttd_pkg::FMT_RGBA8);
  assign fmt_ok  = (cfg.fmt == ttd_pkg::FMT_I8) || (cfg.fmt == ttd_pkg::FMT_I4) || is_rgba;
  assign tw_log  = is_rgba ? 2'd2 : 2'd3;
  assign th_log  = (cfg.fmt == ttd_pkg::FMT_I4) ? 2'd3 : 2'd2;

  // tiles across / down: ceil(dim / tile side)
  assign across = (w_ext + (ttd_pkg::POS_W'(1) << tw_log) - ttd_pkg::POS_W'(1)) >> tw_log;
  assign down   = (h_ext + (ttd_pkg::POS_W'(1) << th_log) - ttd_pkg::POS_W'(1)) >> th_log;

  // byte index within the tile, wrapped to the current tile size
  assign b        = is_rgba ? bit_e : {1'b0, bit_e[4:0]};
  assign tile_end = is_rgba ? (b == 6'd63) : (b[4:0] == 5'd31);

  assign bx = ttd_pkg::POS_W'(col_e) << tw_log;
  assign by = ttd_pkg::POS_W'(row_e) << th_log;

  assign col_inc = ttd_pkg::POS_W'(col_e) + ttd_pkg::POS_W'(1);
  assign row_inc = ttd_pkg::POS_W'(row_e) + ttd_pkg::POS_W'(1);

  // pair slot for RGBA8: same index for the AR and the GB half of the tile
  assign p    = b[4:1];
  assign hi   = {source_byte[7:4], source_byte[7:4]};
  assign lo   = {source_byte[3:0], source_byte[3:0]};

  function automatic ttd_pkg::pixel_t mk_pix(
    input logic [ttd_pkg::POS_W-1:0] x,
    input logic [ttd_pkg::POS_W-1:0] y,
    input logic [ttd_pkg::POS_W-1:0] wd,
    input logic [ttd_pkg::POS_W-1:0] ht,
    input logic [7:0] r, input logic [7:0] g, input logic [7:0] bl, input logic [7:0] a
  );
    ttd_pkg::pixel_t px;
    px.pixel_x    = x[ttd_pkg::COORD_W-1:0];
    px.pixel_y    = y[ttd_pkg::COORD_W-1:0];
    px.red        = r;
    px.green      = g;
    px.blue       = bl;
    px.alpha      = a;
    px.last_pixel = (x == wd - ttd_pkg::POS_W'(1)) && (y == ht - ttd_pkg::POS_W'(1));
    return px;
  endfunction

  always_comb begin
    x0   = bx;
    y0   = by;
    x1   = bx;
    pair = '0;
    case (cfg.fmt)
      ttd_pkg::FMT_I8: begin
        x0      = bx + ttd_pkg::POS_W'(b[2:0]);
        y0      = by + ttd_pkg::POS_W'(b[4:3]);
        pair.v0 = (x0 < w_ext) && (y0 < h_ext);
        pair.p0 = mk_pix(x0, y0, w_ext, h_ext, source_byte, source_byte, source_byte,
                         source_byte);
      end
      ttd_pkg::FMT_I4: begin
        x0      = bx + ttd_pkg::POS_W'({b[1:0], 1'b0});
        x1      = x0 + ttd_pkg::POS_W'(1);
        y0      = by + ttd_pkg::POS_W'(b[4:2]);
        // left texel is always the one that survives first, so slots stay packed
        pair.v0 = (x0 < w_ext) && (y0 < h_ext);
        pair.v1 = (x1 < w_ext) && (y0 < h_ext);
        pair.p0 = mk_pix(x0, y0, w_ext, h_ext, hi, hi, hi, hi);
        pair.p1 = mk_pix(x1, y0, w_ext, h_ext, lo, lo, lo, lo);
      end
      ttd_pkg::FMT_RGBA8: begin
        x0      = bx + ttd_pkg::POS_W'(p[1:0]);
        y0      = by + ttd_pkg::POS_W'(p[3:2]);
        pair.v0 = b[5] && b[0] && (x0 < w_ext) && (y0 < h_ext);
        pair.p0 = mk_pix(x0, y0, w_ext, h_ext, ar_r_r, green_r, source_byte, ar_a_r);
      end
      default: begin
        pair = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      bit_r   <= '0;
      green_r <= '0;
    end else if (accept) begin
      if (!fmt_ok) begin
        col_r <= col_e;
        row_r <= row_e;
        bit_r <= bit_e;
      end else if (tile_end) begin
        bit_r <= '0;
        if (col_inc >= across) begin
          col_r <= '0;
          row_r <= (row_inc >= down) ? '0 : row_inc[ttd_pkg::TILE_W-1:0];
        end else begin
          col_r <= col_inc[ttd_pkg::TILE_W-1:0];
          row_r <= row_e;
        end
      end else begin
        col_r <= col_e;
        row_r <= row_e;
        bit_r <= b + ttd_pkg::BYTE_W'(1);
      end
      if (is_rgba && b[5] && !b[0]) begin
        green_r <= source_byte;
      end
    end
  end

  // AR pair store, no reset: a GB pair is only ever matched with a written AR pair.
  // The G byte fetches its AR pair; the B byte that follows it uses the fetched copy.
  always_ff @(posedge clk) begin
    if (accept && is_rgba) begin
      if (!b[5]) begin
        if (!b[0]) begin
          alpha_mem[p] <= source_byte;
        end else begin
          red_mem[p] <= source_byte;
        end
      end else if (!b[0]) begin
        ar_a_r <= alpha_mem[p];
        ar_r_r <= red_mem[p];
      end
    end
  end

endmodule

// ===== hw/rtl/tiled_texture_decoder_core.sv =====
// Top level of the tiled texture decoder: config registers, pixel queue, output register.
// Usage:
//   in_ch   - one texture byte per transaction in memory order; first_byte restarts
//             the tile walk at the first byte of a texture.
//   out_ch  - one RGBA pixel with its coordinates per transaction; last_pixel marks
//             the bottom right pixel. Texels outside the image give no pixel.
//   cfg_ch  - register writes (0 format, 1 width, 2 height); always ready, write
//             only while no byte is in flight.
// Path: a byte's pixels are registered into the pixel queue, then into the output register.
// Throughput: I8 and RGBA8 take one byte per cycle while out_ch.ready is high; an I4
//   byte yields two pixels through the single output register, so a new I4 byte waits
//   while both are queued; the two-entry pixel queue sets the rate, one pixel per cycle.
// Reset (rst_n low, synchronous): format I8, width 1, height 1, tile walk at the
//   first tile, queue and output register empty. The AR pair store is not cleared.
// Stall: while out_ch.ready is low the output register holds its pixel; one byte's
//   pixels wait in the queue and in_ch.ready drops once the queue cannot take more.
`include "tiled_texture_decoder_core_macros.svh"

module tiled_texture_decoder_core (
  input logic       clk,
  input logic       rst_n,
  ttd_in_if.sink    in_ch,
  ttd_out_if.source out_ch,
  ttd_cfg_if.sink   cfg_ch
);

  ttd_pkg::fmt_t             fmt_r;
  logic [ttd_pkg::DIM_W-1:0] width_r, height_r;
  ttd_pkg::cfg_t             cfg;
  ttd_pkg::pix_pair_t        pair;

  logic            v0_r, v1_r, out_valid_r;
  ttd_pkg::pixel_t s0_r, s1_r, out_r;
  logic            move, in_ready, accept;

  assign cfg.fmt    = fmt_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= ttd_pkg::FMT_I8;
      width_r  <= ttd_pkg::DIM_W'(1);
      height_r <= ttd_pkg::DIM_W'(1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        ttd_pkg::REG_FORMAT: fmt_r    <= ttd_pkg::fmt_t'(cfg_ch.write_data[1:0]);
        ttd_pkg::REG_WIDTH:  width_r  <= cfg_ch.write_data;
        ttd_pkg::REG_HEIGHT: height_r <= cfg_ch.write_data;
        default: begin
        end
      endcase
    end
  end

  // head of the queue moves into the output register when that is free
  assign move     = v0_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !v0_r || (move && !v1_r);
  assign accept   = in_ch.valid && in_ready;

  assign in_ch.ready = in_ready;

  ttd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .source_byte (in_ch.source_byte),
    .first_byte  (in_ch.first_byte),
    .cfg         (cfg),
    .pair        (pair)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (move) begin
        out_valid_r <= 1'b1;
        out_r       <= s0_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        v0_r <= pair.v0;
        v1_r <= pair.v1;
        s0_r <= pair.p0;
        s1_r <= pair.p1;
      end else if (move) begin
        v0_r <= v1_r;
        v1_r <= 1'b0;
        s0_r <= s1_r;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = out_r.pixel_x;
  assign out_ch.pixel_y    = out_r.pixel_y;
  assign out_ch.red        = out_r.red;
  assign out_ch.green      = out_r.green;
  assign out_ch.blue       = out_r.blue;
  assign out_ch.alpha      = out_r.alpha;
  assign out_ch.last_pixel = out_r.last_pixel;

  `TTD_ASSERT_IMPLY(a_queue_packed, v1_r, v0_r, "second queue slot set without the first")
  `TTD_ASSERT_IMPLY(a_full_blocks, v1_r, !in_ready, "byte taken while queue holds two")
  `TTD_ASSERT_NEXT(a_pair_queued, accept && pair.v1, v0_r && v1_r, "I4 pixel pair lost")

endmodule
